// ===== src/i2c_master_byte_engine_core_assert.svh =====
// assertion macros shared by the i2c master byte engine rtl
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define I2CM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define I2CM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/i2cm_pkg.sv =====
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

  // configuration reset values
  localparam logic [7:0] StartStopTicksRst = 8'd4;
  localparam logic [7:0] HalfBitTicksRst   = 8'd2;
  localparam logic [7:0] AckTimeoutRst     = 8'd250;

  // default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgStartStop = 2'd0,
    CfgHalfBit   = 2'd1,
    CfgAckTo     = 2'd2
  } cfg_idx_e;

  // classified command of one tick
  typedef enum logic [2:0] {
    CmdTick  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdWrite = 3'd3,
    CmdRead  = 3'd4
  } cmd_e;

  // one queued tick
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

endpackage

// ===== src/i2cm_front.sv =====
// input side: accepts ticks and classifies the op code
module i2cm_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     op_i,
  input  logic [7:0]     tx_byte_i,
  input  logic           send_ack_i,
  input  logic           sda_in_i,
  input  logic           full_i,
  output logic           push_o,
  output i2cm_pkg::item_t item_o
);
  import i2cm_pkg::*;

  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpStop  = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  cmd_e cmd;

  always_comb begin
    unique case (op_i)
      OpTick:  cmd = CmdTick;
      OpStart: cmd = CmdStart;
      OpStop:  cmd = CmdStop;
      OpWrite: cmd = CmdWrite;
      OpRead:  cmd = CmdRead;
      default: cmd = CmdTick; // unused codes only advance time
    endcase
  end

  assign in_ready_o       = !full_i;
  assign push_o           = in_valid_i && !full_i;
  assign item_o.cmd       = cmd;
  assign item_o.tx_byte   = tx_byte_i;
  assign item_o.send_ack  = send_ack_i;
  assign item_o.sda_in    = sda_in_i;

endmodule

// ===== src/i2cm_queue.sv =====
// small fifo of classified ticks between front and back
module i2cm_queue #(
  parameter int unsigned Depth = i2cm_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cm_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output i2cm_pkg::item_t data_o,
  output logic            empty_o
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);

endmodule

// ===== src/i2cm_back.sv =====
// bus sequencer: timed phases, config registers and the result register
`include "i2c_master_byte_engine_core_assert.svh"

module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  input  i2cm_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            scl_out_o,
  output logic            sda_level_o,
  output logic            sda_enable_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rx_byte_o,
  output logic            ack_missing_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PhIdle   = 4'd0,
    PhStA    = 4'd1,
    PhStB    = 4'd2,
    PhSpA    = 4'd3,
    PhSpB    = 4'd4,
    PhWrLo   = 4'd5,
    PhWrHi   = 4'd6,
    PhAkLo   = 4'd7,
    PhAkPoll = 4'd8,
    PhRdLo   = 4'd9,
    PhRdHi   = 4'd10,
    PhRaLo   = 4'd11,
    PhRaHi   = 4'd12
  } phase_e;

  typedef struct packed {
    logic       scl_out;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  // config registers
  logic [7:0] ss_ticks_q, hb_ticks_q, ack_to_q;

  // engine state
  phase_e     phase_q, phase_d;
  logic [3:0] bit_count_q, bit_count_d;
  logic [7:0] tick_count_q, tick_count_d;
  logic [7:0] poll_count_q, poll_count_d;
  logic [7:0] shift_q, shift_d;
  logic       ack_choice_q, ack_choice_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       oe_q, oe_d;
  logic       fail_q, fail_d;
  logic [7:0] rx_hold_q, rx_hold_d;
  logic       done_d;

  // result register
  logic       out_valid_q, out_valid_d;
  res_t       out_q, out_d;

  logic       step;
  logic [7:0] len, len_eff, to_eff, tick_inc;
  logic [8:0] poll_inc;
  logic [3:0] bc_inc;
  logic       over;

  assign step  = item_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = step;

  always_comb begin
    unique case (phase_q)
      PhStA, PhStB, PhSpA, PhSpB: len = ss_ticks_q;
      default:                    len = hb_ticks_q;
    endcase
    len_eff  = (len == 8'd0) ? 8'd1 : len;
    to_eff   = (ack_to_q == 8'd0) ? 8'd1 : ack_to_q;
    tick_inc = tick_count_q + 8'd1;
    over     = (tick_inc >= len_eff);
    poll_inc = {1'b0, poll_count_q} + 9'd1;
    bc_inc   = bit_count_q + 4'd1;
  end

  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    tick_count_d = tick_count_q;
    poll_count_d = poll_count_q;
    shift_d      = shift_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    oe_d         = oe_q;
    fail_d       = fail_q;
    rx_hold_d    = rx_hold_q;
    done_d       = 1'b0;

    if (step) begin
      if (phase_q != PhIdle && phase_q != PhAkPoll) begin
        tick_count_d = over ? 8'd0 : tick_inc;
      end
      unique case (phase_q)
        PhIdle: begin
          unique case (item_i.cmd)
            CmdStart: begin
              phase_d = PhStA; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1;
              tick_count_d = 8'd0;
            end
            CmdStop: begin
              phase_d = PhSpA; scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1;
              tick_count_d = 8'd0;
            end
            CmdWrite: begin
              fail_d = 1'b0; shift_d = item_i.tx_byte; bit_count_d = 4'd0;
              phase_d = PhWrLo; scl_d = 1'b0; sda_d = item_i.tx_byte[7]; oe_d = 1'b1;
              tick_count_d = 8'd0;
            end
            CmdRead: begin
              shift_d = 8'd0; bit_count_d = 4'd0; ack_choice_d = item_i.send_ack;
              phase_d = PhRdLo; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0;
              tick_count_d = 8'd0;
            end
            default: ;
          endcase
        end
        PhStA: if (over) begin
          phase_d = PhStB; scl_d = 1'b1; sda_d = 1'b0; oe_d = 1'b1;
        end
        PhStB: if (over) begin
          phase_d = PhIdle; scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1; done_d = 1'b1;
        end
        PhSpA: if (over) begin
          phase_d = PhSpB; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1;
        end
        PhSpB: if (over) begin
          phase_d = PhIdle; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1; done_d = 1'b1;
        end
        PhWrLo: if (over) begin
          phase_d = PhWrHi; scl_d = 1'b1; oe_d = 1'b1;
        end
        PhWrHi: if (over) begin
          bit_count_d = bc_inc;
          if (bc_inc < 4'd8) begin
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PhWrLo; scl_d = 1'b0; sda_d = shift_q[6]; oe_d = 1'b1;
          end else begin
            phase_d = PhAkLo; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0;
          end
        end
        PhAkLo: if (over) begin
          poll_count_d = 8'd0;
          phase_d = PhAkPoll; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b0;
        end
        PhAkPoll: begin
          if (!item_i.sda_in) begin
            phase_d = PhIdle; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0;
            tick_count_d = 8'd0; done_d = 1'b1;
          end else if (poll_inc > {1'b0, to_eff}) begin
            fail_d = 1'b1; poll_count_d = 8'd0;
            phase_d = PhSpA; scl_d = 1'b0; sda_d = 1'b0; oe_d = 1'b1;
            tick_count_d = 8'd0;
          end else begin
            poll_count_d = poll_inc[7:0];
          end
        end
        PhRdLo: if (over) begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          phase_d = PhRdHi; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b0;
        end
        PhRdHi: if (over) begin
          bit_count_d = bc_inc;
          if (bc_inc < 4'd8) begin
            phase_d = PhRdLo; scl_d = 1'b0; sda_d = 1'b1; oe_d = 1'b0;
          end else begin
            phase_d = PhRaLo; scl_d = 1'b0; sda_d = !ack_choice_q; oe_d = 1'b1;
          end
        end
        PhRaLo: if (over) begin
          phase_d = PhRaHi; scl_d = 1'b1; oe_d = 1'b1;
        end
        PhRaHi: if (over) begin
          rx_hold_d = shift_q;
          phase_d = PhIdle; scl_d = 1'b0; oe_d = 1'b1; done_d = 1'b1;
        end
        default: begin
          phase_d = PhIdle; scl_d = 1'b1; sda_d = 1'b1; oe_d = 1'b1;
          tick_count_d = 8'd0;
        end
      endcase
    end
  end

  always_comb begin
    out_d.scl_out     = scl_d;
    out_d.sda_level   = oe_d ? sda_d : 1'b1;
    out_d.sda_enable  = oe_d;
    out_d.busy_res    = (phase_d != PhIdle);
    out_d.done_res    = done_d;
    out_d.rx_byte     = rx_hold_d;
    out_d.ack_missing = fail_d;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_ticks_q   <= StartStopTicksRst;
      hb_ticks_q   <= HalfBitTicksRst;
      ack_to_q     <= AckTimeoutRst;
      phase_q      <= PhIdle;
      bit_count_q  <= 4'd0;
      tick_count_q <= 8'd0;
      poll_count_q <= 8'd0;
      shift_q      <= 8'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      oe_q         <= 1'b1;
      fail_q       <= 1'b0;
      rx_hold_q    <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgStartStop: ss_ticks_q <= cfg_data_i;
          CfgHalfBit:   hb_ticks_q <= cfg_data_i;
          CfgAckTo:     ack_to_q   <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      tick_count_q <= tick_count_d;
      poll_count_q <= poll_count_d;
      shift_q      <= shift_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      oe_q         <= oe_d;
      fail_q       <= fail_d;
      rx_hold_q    <= rx_hold_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_out_o     = out_q.scl_out;
  assign sda_level_o   = out_q.sda_level;
  assign sda_enable_o  = out_q.sda_enable;
  assign busy_res_o    = out_q.busy_res;
  assign done_res_o    = out_q.done_res;
  assign rx_byte_o     = out_q.rx_byte;
  assign ack_missing_o = out_q.ack_missing;

  `I2CM_ASSERT(a_done_not_busy, clk_i, rst_ni, out_valid_q && out_q.done_res |-> !out_q.busy_res, "completion reported while still busy")
  `I2CM_ASSERT_NEVER(a_bit_count_range, clk_i, rst_ni, bit_count_q > 4'd8, "bit counter past eight")
  `I2CM_ASSERT(a_idle_tick_clear, clk_i, rst_ni, phase_q == PhIdle |-> tick_count_q == 8'd0, "tick counter not cleared in idle")
  `I2CM_ASSERT(a_pop_loads_result, clk_i, rst_ni, pop_o |=> out_valid_q, "popped tick left no result")

endmodule

// ===== src/i2c_master_byte_engine_core.sv =====
// top level of the i2c master byte engine: front, queue and bus sequencer
//
//   channel  signals                                   direction
//   in       in_valid_i/in_ready_o, op, tx_byte, ...   tick transactions into the block
//   cfg      cfg_valid_i/cfg_ready_o, index, data      register writes, always ready
//   out      out_valid_o/out_ready_i, scl_out, ...     one result per tick transaction
//
// one tick per clock sustained while out_ready_i stays high; a tick is written to
// the queue at the edge that takes it and is popped into the result register once
// the result slot is free; the sequencer step is the single loop that sets that figure
// reset leaves the queue empty, no result pending and the sequencer driving scl and sda high
// a stalled result holds the sequencer; the queue then fills and drops in_ready_o
module i2c_master_byte_engine_core #(
  parameter int unsigned QueueDepth = i2cm_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // tick input
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] tx_byte_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // results
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_level_o,
  output logic       sda_enable_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_missing_o
);
  import i2cm_pkg::*;

  // front to queue
  logic  push, full;
  item_t push_item;
  // queue to back
  logic  pop, empty;
  item_t head_item;

  // config writes always taken; user must keep them between commands, unenforced
  assign cfg_ready_o = 1'b1;

  // decode op codes, unused codes become plain ticks
  i2cm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .tx_byte_i  (tx_byte_i),
    .send_ack_i (send_ack_i),
    .sda_in_i   (sda_in_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // decouples input acceptance from result back-pressure
  i2cm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_item),
    .empty_o (empty)
  );

  // phase sequencer plus registered result slot
  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .item_i        (head_item),
    .item_valid_i  (!empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_out_o     (scl_out_o),
    .sda_level_o   (sda_level_o),
    .sda_enable_o  (sda_enable_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_missing_o (ack_missing_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the i2c master byte engine: directed ticks, then random bus traffic
module tb_top;
  import i2cm_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int unsigned CycleLimit = 200000;
  // op codes outside the command set, handled as plain ticks
  localparam logic [2:0] OpSpareA = 3'd5;
  localparam logic [2:0] OpSpareB = 3'd6;
  localparam logic [2:0] OpSpareC = 3'd7;

  // sequencer phases as tracked by the predictor
  typedef enum logic [3:0] {
    PhIdle, PhStartA, PhStartB, PhStopA, PhStopB, PhWrLow, PhWrHigh,
    PhAckLow, PhAckPoll, PhRdLow, PhRdHigh, PhRaLow, PhRaHigh
  } bus_phase_e;

  // one result transaction
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       oe;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       miss;
  } bus_result_t;

  // bus at rest, as left by reset or by a tick with nothing to do
  localparam bus_result_t BusAtRest = '{scl: 1'b1, sda: 1'b1, oe: 1'b1, busy: 1'b0,
                                        done: 1'b0, rx: 8'h00, miss: 1'b0};
  // end of the stop issued after a missing ack
  localparam bus_result_t BusAckLost = '{scl: 1'b1, sda: 1'b1, oe: 1'b1, busy: 1'b0,
                                         done: 1'b1, rx: 8'h00, miss: 1'b1};

  // directed plan: a tick row sends its op, then hold plain ticks with the same fields
  typedef enum logic {RowTick, RowCfg} row_kind_e;
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  op;
    logic [7:0]  tx;
    logic        ack;
    logic        sda;
    int unsigned hold;
    logic        pinned;  // last tick of the row checked against want
    bus_result_t want;
    cfg_idx_e    sel;
  } plan_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] op_i;
  logic [7:0] tx_byte_i;
  logic       send_ack_i;
  logic       sda_in_i;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       scl_out_o;
  logic       sda_level_o;
  logic       sda_enable_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;
  logic       ack_missing_o;

  i2c_master_byte_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .tx_byte_i     (tx_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_in_i      (sda_in_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_out_o     (scl_out_o),
    .sda_level_o   (sda_level_o),
    .sda_enable_o  (sda_enable_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_missing_o (ack_missing_o)
  );

  // predictor copy of the sequencer and its registers
  logic [7:0] cfg_ss = StartStopTicksRst;
  logic [7:0] cfg_hb = HalfBitTicksRst;
  logic [7:0] cfg_to = AckTimeoutRst;
  bus_phase_e ph = PhIdle;
  logic [3:0] bit_idx = '0;
  logic [7:0] tick_cnt = '0;
  logic [7:0] poll_cnt = '0;
  logic [7:0] shifter = '0;
  logic       ack_pick = 1'b0;
  logic       scl_q = 1'b1;
  logic       sda_q = 1'b1;
  logic       oe_q = 1'b1;
  logic       miss_q = 1'b0;
  logic [7:0] rx_q = '0;

  bus_result_t bus_expect_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;
  bit          steady = 1'b0;  // no idling on either side while set

  // random traffic shaping
  int unsigned seq_pos = 0;
  int unsigned data_left = 0;
  int unsigned sda_low_pct = 50;

  plan_row_t plan [20];

  // 100 MHz-style clock, period 10
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // a break with a chance of about 16 in a hundred, none while steady
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 16);
  endfunction

  // ---- predictor ----

  // move to a new phase with its bus drive, restart the tick count
  function automatic void go_phase(bus_phase_e p, logic scl, logic sda, logic oe);
    ph = p;
    scl_q = scl;
    sda_q = sda;
    oe_q = oe;
    tick_cnt = '0;
  endfunction

  // one tick in a timed phase; true when the phase length is reached (zero acts as one)
  function automatic logic count_tick(logic [7:0] len);
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= ((len == 8'd0) ? 8'd1 : len)) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the engine by one tick and return the bus state after it
  function automatic bus_result_t sequencer_step(logic [2:0] op, logic [7:0] tx, logic ack,
                                                 logic sda);
    logic        done;
    logic [8:0]  polls;
    logic [8:0]  poll_max;
    bus_result_t r;
    done = 1'b0;
    case (ph)
      PhIdle: begin
        // commands are taken only here; anything else is a plain tick
        case (op)
          CmdStart: go_phase(PhStartA, 1'b1, 1'b1, 1'b1);
          CmdStop:  go_phase(PhStopA, 1'b0, 1'b0, 1'b1);
          CmdWrite: begin
            miss_q = 1'b0;
            shifter = tx;
            bit_idx = '0;
            go_phase(PhWrLow, 1'b0, tx[7], 1'b1);
          end
          CmdRead: begin
            shifter = '0;
            bit_idx = '0;
            ack_pick = ack;
            go_phase(PhRdLow, 1'b0, 1'b1, 1'b0);
          end
          default: ;
        endcase
      end
      PhStartA: if (count_tick(cfg_ss)) go_phase(PhStartB, 1'b1, 1'b0, 1'b1);
      PhStartB: begin
        if (count_tick(cfg_ss)) begin
          go_phase(PhIdle, 1'b0, 1'b0, 1'b1);
          done = 1'b1;
        end
      end
      PhStopA: if (count_tick(cfg_ss)) go_phase(PhStopB, 1'b1, 1'b1, 1'b1);
      PhStopB: begin
        if (count_tick(cfg_ss)) begin
          go_phase(PhIdle, 1'b1, 1'b1, 1'b1);
          done = 1'b1;
        end
      end
      PhWrLow: if (count_tick(cfg_hb)) go_phase(PhWrHigh, 1'b1, sda_q, 1'b1);
      PhWrHigh: begin
        if (count_tick(cfg_hb)) begin
          bit_idx = bit_idx + 4'd1;
          if (bit_idx < 4'd8) begin
            shifter = shifter << 1;
            go_phase(PhWrLow, 1'b0, shifter[7], 1'b1);
          end else begin
            go_phase(PhAckLow, 1'b0, 1'b1, 1'b0);
          end
        end
      end
      PhAckLow: begin
        if (count_tick(cfg_hb)) begin
          poll_cnt = '0;
          go_phase(PhAckPoll, 1'b1, 1'b1, 1'b0);
        end
      end
      PhAckPoll: begin
        // slave pulls sda low: ack seen; stays high too long: stop and flag
        if (!sda) begin
          go_phase(PhIdle, 1'b0, 1'b1, 1'b0);
          done = 1'b1;
        end else begin
          polls = {1'b0, poll_cnt} + 9'd1;
          poll_max = {1'b0, (cfg_to == 8'd0) ? 8'd1 : cfg_to};
          if (polls > poll_max) begin
            miss_q = 1'b1;
            poll_cnt = '0;
            go_phase(PhStopA, 1'b0, 1'b0, 1'b1);
          end else begin
            poll_cnt = polls[7:0];
          end
        end
      end
      PhRdLow: begin
        // sample as scl rises
        if (count_tick(cfg_hb)) begin
          shifter = {shifter[6:0], sda};
          go_phase(PhRdHigh, 1'b1, 1'b1, 1'b0);
        end
      end
      PhRdHigh: begin
        if (count_tick(cfg_hb)) begin
          bit_idx = bit_idx + 4'd1;
          if (bit_idx < 4'd8) go_phase(PhRdLow, 1'b0, 1'b1, 1'b0);
          else go_phase(PhRaLow, 1'b0, !ack_pick, 1'b1);
        end
      end
      PhRaLow: if (count_tick(cfg_hb)) go_phase(PhRaHigh, 1'b1, sda_q, 1'b1);
      PhRaHigh: begin
        if (count_tick(cfg_hb)) begin
          rx_q = shifter;
          go_phase(PhIdle, 1'b0, sda_q, 1'b1);
          done = 1'b1;
        end
      end
      default: go_phase(PhIdle, 1'b1, 1'b1, 1'b1);
    endcase
    r.scl = scl_q;
    r.sda = oe_q ? sda_q : 1'b1;  // released sda reads high
    r.oe = oe_q;
    r.busy = (ph != PhIdle);
    r.done = done;
    r.rx = rx_q;
    r.miss = miss_q;
    return r;
  endfunction

  // ---- stimulus ----

  // one tick transaction; the expectation is pushed at the accepting edge
  task automatic send_tick(logic [2:0] op, logic [7:0] tx, logic ack, logic sda,
                           logic pinned, bus_result_t want);
    bus_result_t predicted;
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    tx_byte_i <= tx;
    send_ack_i <= ack;
    sda_in_i <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = sequencer_step(op, tx, ack, sda);
    bus_expect_q.push_back(pinned ? want : predicted);
  endtask

  // stop sending and wait until every result is back and the pipe is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e sel, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (sel)
      CfgStartStop: cfg_ss = val;
      CfgHalfBit:   cfg_hb = val;
      default:      cfg_to = val;
    endcase
    @(posedge clk_i);
  endtask

  // random tick: mostly well-formed start / address / data / stop sequences
  task automatic random_tick();
    logic [2:0] op;
    logic       sda;
    if (ph != PhIdle) begin
      // engine busy: commands here must be ignored
      op = ($urandom_range(99) < 8) ? 3'($urandom_range(7)) : CmdTick;
    end else if ($urandom_range(99) < 20) begin
      op = CmdTick;
    end else if ($urandom_range(99) < 12) begin
      // noise and broken sequences
      op = 3'($urandom_range(7));
    end else begin
      case (seq_pos)
        0: begin
          op = CmdStart;
          seq_pos = 1;
          data_left = $urandom_range(4, 1);
        end
        1: begin
          op = CmdWrite;
          seq_pos = 2;
        end
        default: begin
          if (data_left != 0) begin
            op = $urandom_range(1) ? CmdWrite : CmdRead;
            data_left--;
          end else begin
            op = CmdStop;
            seq_pos = 0;
          end
        end
      endcase
    end
    // each command gets its own slave behavior: mostly ack, mixed, or mostly silent
    if (ph == PhIdle && op != CmdTick) begin
      case ($urandom_range(2))
        0: sda_low_pct = 90;
        1: sda_low_pct = 50;
        default: sda_low_pct = 10;
      endcase
    end
    sda = !($urandom_range(99) < sda_low_pct);
    send_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)), sda, 1'b0, BusAtRest);
  endtask

  function automatic plan_row_t tick_row(logic [2:0] op, logic [7:0] tx, logic ack, logic sda,
                                         int unsigned hold);
    plan_row_t r;
    r = '0;
    r.kind = RowTick;
    r.op = op;
    r.tx = tx;
    r.ack = ack;
    r.sda = sda;
    r.hold = hold;
    return r;
  endfunction

  function automatic plan_row_t pin_row(logic [2:0] op, logic [7:0] tx, logic ack, logic sda,
                                        int unsigned hold, bus_result_t want);
    plan_row_t r;
    r = tick_row(op, tx, ack, sda, hold);
    r.pinned = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_e sel, logic [7:0] val);
    plan_row_t r;
    r = '0;
    r.kind = RowCfg;
    r.sel = sel;
    r.tx = val;
    return r;
  endfunction

  // receiver side: random backpressure
  always @(posedge clk_i) begin
    out_ready_i <= !take_break();
  end

  // result checker
  always @(posedge clk_i) begin : check_result
    bus_result_t got;
    bus_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{scl: scl_out_o, sda: sda_level_o, oe: sda_enable_o, busy: busy_res_o,
              done: done_res_o, rx: rx_byte_o, miss: ack_missing_o};
      results_seen <= results_seen + 1;
      if (bus_expect_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("result %0d: no tick outstanding, got %p", results_seen, got);
      end else begin
        want = bus_expect_q.pop_front();
        if (got !== want) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display({"result %0d exp/act: scl %b/%b sda %b/%b oe %b/%b busy %b/%b",
                      " done %b/%b rx %h/%h miss %b/%b"}, results_seen,
                     want.scl, got.scl, want.sda, got.sda, want.oe, got.oe,
                     want.busy, got.busy, want.done, got.done, want.rx, got.rx,
                     want.miss, got.miss);
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= CmdTick;
    tx_byte_i <= '0;
    send_ack_i <= 1'b0;
    sda_in_i <= 1'b1;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgStartStop;
    cfg_data_i <= '0;

    plan = '{
      // reset state and the spare op codes, which only tick
      pin_row(CmdTick, 8'h00, 1'b0, 1'b1, 0, BusAtRest),
      pin_row(OpSpareA, 8'hff, 1'b1, 1'b0, 0, BusAtRest),
      pin_row(OpSpareB, 8'h00, 1'b0, 1'b1, 0, BusAtRest),
      pin_row(OpSpareC, 8'hff, 1'b1, 1'b1, 0, BusAtRest),
      // default timing: start, writes acked, read with ack of all ones, read with nack of zeros
      tick_row(CmdStart, 8'h00, 1'b0, 1'b1, 8),
      tick_row(CmdWrite, 8'hff, 1'b0, 1'b0, 40),
      tick_row(CmdWrite, 8'h00, 1'b1, 1'b0, 40),
      tick_row(CmdRead, 8'h00, 1'b1, 1'b1, 40),
      tick_row(CmdRead, 8'hff, 1'b0, 1'b0, 40),
      // a start, commands arriving while it is busy are dropped, then a stop
      tick_row(CmdStart, 8'h00, 1'b0, 1'b1, 0),
      tick_row(CmdWrite, 8'h55, 1'b0, 1'b0, 0),
      tick_row(CmdStop, 8'h00, 1'b0, 1'b1, 12),
      tick_row(CmdStop, 8'h00, 1'b0, 1'b1, 10),
      // zero lengths act as one; shortest ack timeout
      cfg_row(CfgStartStop, 8'd0),
      cfg_row(CfgHalfBit, 8'd0),
      cfg_row(CfgAckTo, 8'd1),
      // silent slave: timeout stop, then a new write clears the flag
      pin_row(CmdWrite, 8'ha5, 1'b0, 1'b1, 21, BusAckLost),
      tick_row(CmdWrite, 8'h5a, 1'b1, 1'b0, 20),
      // longest ack timeout runs out
      cfg_row(CfgAckTo, 8'd255),
      tick_row(CmdWrite, 8'h3c, 1'b0, 1'b1, 300)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        settle();
        write_reg(plan[i].sel, plan[i].tx);
      end else begin
        send_tick(plan[i].op, plan[i].tx, plan[i].ack, plan[i].sda,
                  plan[i].pinned && plan[i].hold == 0, plan[i].want);
        for (int k = 1; k <= plan[i].hold; k++)
          send_tick(CmdTick, plan[i].tx, plan[i].ack, plan[i].sda,
                    plan[i].pinned && k == plan[i].hold, plan[i].want);
      end
    end

    // random part: several short timing settings, one phase with no idling
    for (int p = 0; p < 5; p++) begin
      while (ph != PhIdle) random_tick();
      settle();
      steady = (p == 2);
      write_reg(CfgStartStop, 8'($urandom_range(6, 1)));
      write_reg(CfgHalfBit, 8'($urandom_range(4, 1)));
      write_reg(CfgAckTo, ($urandom_range(3) == 0) ? 8'($urandom_range(60, 9))
                                                   : 8'($urandom_range(8, 1)));
      repeat (130) random_tick();
    end
    steady = 1'b0;

    // wind down
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && bus_expect_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
